// ----- sv/arpns_pkg.sv -----
package arpns_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_STEP     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] key;
    logic [6:0] strike;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } out_word_t;

  // register indexes
  localparam logic [1:0] REG_PATTERN  = 2'd0;
  localparam logic [1:0] REG_OCTAVES  = 2'd1;
  localparam logic [1:0] REG_VELOCITY = 2'd2;
  localparam logic [1:0] REG_LATCH    = 2'd3;

  // pattern modes
  localparam logic [3:0] MODE_UP       = 4'd0;
  localparam logic [3:0] MODE_DOWN     = 4'd1;
  localparam logic [3:0] MODE_UPDOWN   = 4'd2;
  localparam logic [3:0] MODE_DOWNUP   = 4'd3;
  localparam logic [3:0] MODE_UPDOWN_I = 4'd4;
  localparam logic [3:0] MODE_CONVERGE = 4'd5;
  localparam logic [3:0] MODE_DIVERGE  = 4'd6;
  localparam logic [3:0] MODE_PLAYED   = 4'd7;
  localparam logic [3:0] MODE_CHORD    = 4'd8;

  // velocity rules
  localparam logic [1:0] VEL_FIXED  = 2'd1;
  localparam logic [1:0] VEL_ACCENT = 2'd2;

  localparam logic [6:0] NOTE_MAX      = 7'd127;
  localparam logic [6:0] VEL_FIXED_VAL = 7'd100;
  localparam logic [6:0] VEL_ACCENT_HI = 7'd127;
  localparam logic [6:0] VEL_ACCENT_LO = 7'd88;
  localparam logic [7:0] SEMITONES     = 8'd12;
  localparam int         MAX_RESULTS   = 32;
  localparam int         DIV_BITS      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_POS,
    ST_DIV2,
    ST_EMIT,
    ST_CHORD
  } state_t;

  // ranking control shared by all cells
  typedef struct packed {
    logic rank_load;
    logic rank_run;
  } cell_ctl_t;

endpackage

// ----- sv/arpns_cell.sv -----
module arpns_cell import arpns_pkg::*; #(
  parameter int RW = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic          wr_key,
  input  logic          wr_strike,
  input  logic          take_next,
  input  logic [6:0]    new_key,
  input  logic [6:0]    new_strike,
  input  logic [6:0]    nb_key,
  input  logic [6:0]    nb_strike,
  input  logic          own_valid,
  input  logic [6:0]    probe_key_in,
  input  logic          probe_vld_in,
  output logic [6:0]    probe_key,
  output logic          probe_vld,
  output logic [6:0]    key,
  output logic [6:0]    strike,
  output logic [RW-1:0] rank
);

  logic [6:0]    key_r, strike_r, probe_key_r;
  logic          probe_vld_r;
  logic [RW-1:0] rank_r;

  // held note, written in place or shifted down from the neighbour
  always_ff @(posedge clk) begin
    if (wr_key) begin
      key_r <= new_key;
    end else if (take_next) begin
      key_r <= nb_key;
    end
    if (wr_strike) begin
      strike_r <= new_strike;
    end else if (take_next) begin
      strike_r <= nb_strike;
    end
  end

  // pitch rank: probes circulate round the ring, count the lower ones
  always_ff @(posedge clk) begin
    if (ctl.rank_load) begin
      probe_key_r <= key_r;
      probe_vld_r <= own_valid;
      rank_r      <= '0;
    end else if (ctl.rank_run) begin
      probe_key_r <= probe_key_in;
      probe_vld_r <= probe_vld_in;
      if (probe_vld_in && (probe_key_in < key_r)) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  assign probe_key = probe_key_r;
  assign probe_vld = probe_vld_r;
  assign key       = key_r;
  assign strike    = strike_r;
  assign rank      = rank_r;

endmodule

// ----- sv/arpns_div.sv -----
module arpns_div import arpns_pkg::*; #(
  parameter int LW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [LW-1:0]       divisor,
  output logic                busy,
  output logic [DIV_BITS-1:0] quot,
  output logic [LW-1:0]       rem
);

  localparam int CNTW = $clog2(DIV_BITS);

  logic [DIV_BITS-1:0] dvd_r;
  logic [LW-1:0]       rem_r, dvs_r;
  logic [CNTW-1:0]     cnt_r;
  logic                busy_r;
  logic [LW:0]         trial;
  logic                ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, dvd_r[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNTW'(DIV_BITS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? LW'(trial - {1'b0, dvs_r}) : trial[LW-1:0];
      dvd_r <= {dvd_r[DIV_BITS-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

// ----- sv/arpeggiator_note_selector.sv -----
// Arpeggiator note selector. Note-on, note-off and clear words are done in
// the idle state. A step word runs a shared bit-serial divider twice (step
// count modulo pattern length, then position by held-note count) while pitch
// ranks are found by passing each held key once round the ring of MAX_HELD
// note cells. A chord step gives one note a cycle while the output register
// is free, up to 32 notes. Results wait in an output register; the next
// input word is taken once the current one has handed over its last result.
module arpeggiator_note_selector import arpns_pkg::*; #(
  parameter int MAX_HELD = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int SW = $clog2(MAX_HELD * 7 + 1);
  localparam int LW = $clog2(2 * MAX_HELD * 7 + 1);

  state_t state_r, state_nxt;

  logic [3:0]  pattern_mode_r;
  logic [2:0]  octave_span_r;
  logic [1:0]  velocity_rule_r;
  logic        latch_on_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] step_count_r;
  logic        chord_down_r;
  logic        accent_r;
  logic [IW-1:0] cidx_r;
  logic        rank_busy_r;
  logic [IW-1:0] rk_cnt_r;
  logic        out_valid_r;
  out_word_t   out_word_r;

  // cell ring
  logic [6:0]    c_key [MAX_HELD];
  logic [6:0]    c_strike [MAX_HELD];
  logic [IW-1:0] c_rank [MAX_HELD];
  logic [6:0]    p_key [MAX_HELD];
  logic          p_vld [MAX_HELD];
  logic [MAX_HELD-1:0] wr_key_v, wr_strike_v, take_next_v, valid_v, match_v;
  cell_ctl_t     cell_ctl;
  logic [6:0]    strike_fix;
  logic [CW-1:0] cmp_cnt;

  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    localparam int PREV = (i + MAX_HELD - 1) % MAX_HELD;
    localparam int NEXT = (i + 1 < MAX_HELD) ? i + 1 : i;
    assign valid_v[i] = CW'(i) < cnt_r;
    arpns_cell #(.RW(IW)) u_cell (
      .clk          (clk),
      .ctl          (cell_ctl),
      .wr_key       (wr_key_v[i]),
      .wr_strike    (wr_strike_v[i]),
      .take_next    (take_next_v[i]),
      .new_key      (in_data.key),
      .new_strike   (strike_fix),
      .nb_key       (c_key[NEXT]),
      .nb_strike    (c_strike[NEXT]),
      .own_valid    (valid_v[i]),
      .probe_key_in (p_key[PREV]),
      .probe_vld_in (p_vld[PREV]),
      .probe_key    (p_key[i]),
      .probe_vld    (p_vld[i]),
      .key          (c_key[i]),
      .strike       (c_strike[i]),
      .rank         (c_rank[i])
    );
  end

  // divider
  logic                div_start, div_busy;
  logic [DIV_BITS-1:0] div_dvd, div_quot;
  logic [LW-1:0]       div_dvs, div_rem;

  arpns_div #(.LW(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // pattern geometry
  logic [2:0]    oct;
  logic [SW-1:0] span;
  logic [LW-1:0] span_l, len, pos, step_v, half, c_l;

  assign oct    = (octave_span_r == 3'd0) ? 3'd1 : octave_span_r;
  assign span   = SW'(cnt_r) * SW'(oct);
  assign span_l = LW'(span);

  always_comb begin
    unique case (pattern_mode_r)
      MODE_UPDOWN, MODE_DOWNUP: len = (span_l > LW'(1)) ? (span_l << 1) - LW'(2) : LW'(1);
      MODE_UPDOWN_I:            len = span_l << 1;
      default:                  len = span_l;
    endcase
  end

  // position within the pattern from the step
  logic [LW-1:0] up;
  always_comb begin
    step_v = div_rem;
    half   = step_v >> 1;
    c_l    = span_l >> 1;
    up     = (step_v < span_l) ? step_v : (span_l << 1) - LW'(2) - step_v;
    unique case (pattern_mode_r)
      MODE_DOWN:     pos = span_l - LW'(1) - step_v;
      MODE_UPDOWN:   pos = up;
      MODE_DOWNUP:   pos = span_l - LW'(1) - up;
      MODE_UPDOWN_I: pos = (step_v < span_l) ? step_v : (span_l << 1) - LW'(1) - step_v;
      MODE_CONVERGE: pos = step_v[0] ? span_l - LW'(1) - half : half;
      MODE_DIVERGE: begin
        if (!step_v[0]) begin
          pos = c_l + half;
        end else if (half + LW'(1) > c_l) begin
          pos = span_l - LW'(1);
        end else begin
          pos = c_l - LW'(1) - half;
        end
      end
      default:       pos = step_v;
    endcase
  end

  // read port over the cells
  logic          use_rank;
  logic [IW-1:0] target;
  logic [6:0]    sel_key, sel_strike;
  always_comb begin
    sel_key    = '0;
    sel_strike = '0;
    for (int i = 0; i < MAX_HELD; i++) begin
      if (valid_v[i] && (use_rank ? (c_rank[i] == target) : (IW'(i) == target))) begin
        sel_key    = sel_key | c_key[i];
        sel_strike = sel_strike | c_strike[i];
      end
    end
  end

  logic [7:0] note_sum;
  logic [6:0] note_out, vel_out;
  logic       accent_now;
  assign note_sum = 8'(sel_key) + 8'(div_quot[3:0]) * SEMITONES;
  assign note_out = (state_r == ST_CHORD) ? sel_key
                  : ((note_sum > 8'(NOTE_MAX)) ? NOTE_MAX : note_sum[6:0]);
  assign accent_now = (state_r == ST_CHORD) ? !step_count_r[0] : accent_r;
  always_comb begin
    unique case (velocity_rule_r)
      VEL_FIXED:  vel_out = VEL_FIXED_VAL;
      VEL_ACCENT: vel_out = accent_now ? VEL_ACCENT_HI : VEL_ACCENT_LO;
      default:    vel_out = sel_strike;
    endcase
  end

  logic out_free, out_load, chord_last, in_acc;
  assign out_free   = !out_valid_r || out_ready;
  assign chord_last = (32'(cidx_r) + 32'd1 == 32'(cnt_r)) ||
                      (32'(cidx_r) + 32'd1 == MAX_RESULTS);
  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign strike_fix = (in_data.strike == 7'd0) ? 7'd1 : in_data.strike;
  assign cmp_cnt    = (in_data.op == OP_NOTE_ON && latch_on_r && !chord_down_r) ? '0 : cnt_r;

  // key match against the held table
  always_comb begin
    for (int i = 0; i < MAX_HELD; i++) begin
      match_v[i] = (CW'(i) < cmp_cnt) && (c_key[i] == in_data.key);
    end
  end

  // next state, table updates and strobes
  always_comb begin
    logic acc;
    acc         = 1'b0;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wr_key_v    = '0;
    wr_strike_v = '0;
    take_next_v = '0;
    cell_ctl    = '0;
    div_start   = 1'b0;
    div_dvd     = step_count_r;
    div_dvs     = len;
    use_rank    = 1'b0;
    target      = cidx_r;
    out_load    = 1'b0;
    cell_ctl.rank_run = rank_busy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.op)
            OP_NOTE_ON: begin
              cnt_nxt = cmp_cnt;
              if (|match_v) begin
                wr_strike_v = match_v;
              end else if (cmp_cnt < CW'(MAX_HELD)) begin
                for (int i = 0; i < MAX_HELD; i++) begin
                  wr_key_v[i]    = (CW'(i) == cmp_cnt);
                  wr_strike_v[i] = (CW'(i) == cmp_cnt);
                end
                cnt_nxt = cmp_cnt + 1'b1;
              end
            end
            OP_NOTE_OFF: begin
              if (!latch_on_r && (|match_v)) begin
                for (int i = 0; i < MAX_HELD; i++) begin
                  acc            = acc | match_v[i];
                  take_next_v[i] = acc;
                end
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_STEP: begin
              if (cnt_r != '0) begin
                if (pattern_mode_r == MODE_CHORD) begin
                  state_nxt = ST_CHORD;
                end else begin
                  div_start          = 1'b1;
                  cell_ctl.rank_load = 1'b1;
                  state_nxt          = ST_DIV1;
                end
              end
            end
            OP_CLEAR: cnt_nxt = '0;
          endcase
        end
      end
      ST_DIV1: begin
        if (!div_busy) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        div_start = 1'b1;
        div_dvd   = DIV_BITS'(pos);
        div_dvs   = LW'(cnt_r);
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        if (!div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        use_rank = (pattern_mode_r != MODE_PLAYED);
        target   = div_rem[IW-1:0];
        if (out_free && !rank_busy_r) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CHORD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (chord_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_mode_r  <= MODE_UP;
      octave_span_r   <= 3'd1;
      velocity_rule_r <= 2'd0;
      latch_on_r      <= 1'b0;
      cnt_r           <= '0;
      step_count_r    <= '0;
      chord_down_r    <= 1'b0;
      cidx_r          <= '0;
      rank_busy_r     <= 1'b0;
      rk_cnt_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN:  pattern_mode_r  <= cfg_data;
          REG_OCTAVES:  octave_span_r   <= cfg_data[2:0];
          REG_VELOCITY: velocity_rule_r <= cfg_data[1:0];
          REG_LATCH:    latch_on_r      <= cfg_data[0];
        endcase
      end
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        unique case (in_data.op)
          OP_NOTE_ON:  chord_down_r <= 1'b1;
          OP_NOTE_OFF: if (latch_on_r) chord_down_r <= 1'b0;
          OP_CLEAR: begin
            chord_down_r <= 1'b0;
            step_count_r <= '0;
          end
          default: ;
        endcase
      end
      // ring passes for ranking
      if (cell_ctl.rank_load) begin
        rank_busy_r <= (MAX_HELD > 1);
        rk_cnt_r    <= '0;
      end else if (rank_busy_r) begin
        rk_cnt_r <= rk_cnt_r + 1'b1;
        if (rk_cnt_r == IW'(MAX_HELD - 2)) begin
          rank_busy_r <= 1'b0;
        end
      end
      if (state_r == ST_IDLE) begin
        cidx_r <= '0;
      end else if (state_r == ST_CHORD && out_load) begin
        cidx_r <= cidx_r + 1'b1;
      end
      if (out_load && (state_r == ST_EMIT || chord_last)) begin
        step_count_r <= step_count_r + 32'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word and accent flag
  always_ff @(posedge clk) begin
    if (state_r == ST_POS) begin
      accent_r <= (div_rem == '0);
    end
    if (out_load) begin
      out_word_r.out_note     <= note_out;
      out_word_r.out_velocity <= vel_out;
      out_word_r.last         <= (state_r == ST_EMIT) || chord_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_HELD))
    else $error("held count beyond table size");

  a_rank_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_load) |-> !rank_busy_r)
    else $error("note picked before ranking finished");

  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == OP_STEP && cnt_r != '0 && pattern_mode_r != MODE_CHORD)
      |=> (state_r == ST_DIV1 && div_busy))
    else $error("step word did not start the divider");

  a_chord_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHORD) |-> (32'(cidx_r) < 32'(cnt_r)))
    else $error("chord index past held notes");

endmodule
